FILE: rtl/core/pc2d_pkg.sv
// ----------------------------------------------------------------------------
// pc2d_pkg
// Shared widths, constants and types for the planar pose composition core.
// ----------------------------------------------------------------------------
package pc2d_pkg;

    // CORDIC iteration count, capped by the size of the arctangent table
    localparam int ITERATIONS   = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int STAGES       = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;

    // Guard bits kept below Q15.16 during the rotation
    localparam int GUARD = 16;

    // Working widths: position in Q.32, angle with 2^31 as pi
    localparam int POS_W = 51;
    localparam int ANG_W = 34;
    localparam int SUM_W = POS_W + 1;
    localparam int RND_W = SUM_W - GUARD;

    // CORDIC gain limit in unsigned Q0.32
    localparam logic [31:0] GAIN_Q032 = 32'h9B74EDA8;

    // Quarter turn in the 16-bit binary angle
    localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;
    localparam logic signed [16:0] HALF_TURN    = 17'sd32768;

    // Payload carried through the rotation stages
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [ANG_W-1:0] ang;
        logic        [31:0]      rx;
        logic        [31:0]      rz;
        logic        [15:0]      hsum;
    } pc2d_rot_t;

    // round(atan(2^-i) * 2^31 / pi)
    function automatic logic signed [ANG_W-1:0] atan_angle(input int idx);
        logic signed [ANG_W-1:0] val;
        begin
            case (idx)
                0:       val = ANG_W'(32'h20000000);
                1:       val = ANG_W'(32'h12E4051E);
                2:       val = ANG_W'(32'h09FB385B);
                3:       val = ANG_W'(32'h051111D4);
                4:       val = ANG_W'(32'h028B0D43);
                5:       val = ANG_W'(32'h0145D7E1);
                6:       val = ANG_W'(32'h00A2F61E);
                7:       val = ANG_W'(32'h00517C55);
                8:       val = ANG_W'(32'h0028BE53);
                9:       val = ANG_W'(32'h00145F2F);
                10:      val = ANG_W'(32'h000A2F98);
                11:      val = ANG_W'(32'h000517CC);
                12:      val = ANG_W'(32'h00028BE6);
                13:      val = ANG_W'(32'h000145F3);
                14:      val = ANG_W'(32'h0000A2FA);
                15:      val = ANG_W'(32'h0000517D);
                16:      val = ANG_W'(32'h000028BE);
                17:      val = ANG_W'(32'h0000145F);
                18:      val = ANG_W'(32'h00000A30);
                19:      val = ANG_W'(32'h00000518);
                20:      val = ANG_W'(32'h0000028C);
                21:      val = ANG_W'(32'h00000146);
                22:      val = ANG_W'(32'h000000A3);
                23:      val = ANG_W'(32'h00000051);
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

FILE: rtl/core/pose_compose_2d.sv
// ----------------------------------------------------------------------------
// pose_compose_2d
// Composes a robot pose with a target pose given in the robot frame:
// CORDIC rotation of the local position, addition of the robot position.
//
//   Channel   Handshake            Fields
//   input     in_valid / in_stall  robot_x robot_z robot_heading
//                                  local_x local_z local_heading
//   output    out_valid/out_stall  global_x global_z global_heading saturated
//
// One beat accepted per cycle unless in_stall is high. Register stages in order: gain multiply,
// scale and fold, one stage per CORDIC iteration, then add, round and clamp.
// The pipeline advances as a whole whenever the output register is empty or
// being taken; in_stall follows out_stall while a result is held.
// Reset clears the valid bits only; no item is in flight after reset.
// ----------------------------------------------------------------------------
module pose_compose_2d (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] robot_x,
    input  logic signed [31:0] robot_z,
    input  logic signed [15:0] robot_heading,
    input  logic signed [31:0] local_x,
    input  logic signed [31:0] local_z,
    input  logic signed [15:0] local_heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] global_x,
    output logic signed [31:0] global_z,
    output logic signed [15:0] global_heading,
    output logic               saturated
);

    logic                advance;
    logic                pre_vld;
    pc2d_pkg::pc2d_rot_t pre_rot;
    logic                cor_vld;
    pc2d_pkg::pc2d_rot_t cor_rot;

    // Move every stage unless the output beat is blocked
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    pc2d_prescale u_prescale (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid),
        .robot_x       (robot_x),
        .robot_z       (robot_z),
        .robot_heading (robot_heading),
        .local_x       (local_x),
        .local_z       (local_z),
        .local_heading (local_heading),
        .rot_valid     (pre_vld),
        .rot           (pre_rot)
    );

    pc2d_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (pre_vld),
        .in_rot    (pre_rot),
        .out_valid (cor_vld),
        .out_rot   (cor_rot)
    );

    pc2d_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (cor_vld),
        .in_rot      (cor_rot),
        .out_valid   (out_valid),
        .out_x       (global_x),
        .out_z       (global_z),
        .out_heading (global_heading),
        .out_sat     (saturated)
    );

endmodule

FILE: rtl/core/pc2d_prescale.sv
// ----------------------------------------------------------------------------
// pc2d_prescale
// Gain compensation and half-turn folding ahead of the CORDIC stages.
// Two register stages: gain multiply, then scale, fold and angle setup.
// ----------------------------------------------------------------------------
module pc2d_prescale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  logic signed [31:0]  robot_x,
    input  logic signed [31:0]  robot_z,
    input  logic signed [15:0]  robot_heading,
    input  logic signed [31:0]  local_x,
    input  logic signed [31:0]  local_z,
    input  logic signed [15:0]  local_heading,
    output logic                rot_valid,
    output pc2d_pkg::pc2d_rot_t rot
);

    // Stage 0 registers
    logic               mul_vld_reg;
    logic signed [63:0] prod_x_reg;
    logic signed [63:0] prod_z_reg;
    logic signed [15:0] rh_reg;
    logic        [31:0] rx_reg;
    logic        [31:0] rz_reg;
    logic        [15:0] hsum_reg;

    // Stage 1 registers
    logic                 rot_vld_reg;
    pc2d_pkg::pc2d_rot_t  rot_reg;
    pc2d_pkg::pc2d_rot_t  rot_next;

    logic signed [64:0] prod_x_full;
    logic signed [64:0] prod_z_full;
    logic signed [pc2d_pkg::POS_W-1:0] sx;
    logic signed [pc2d_pkg::POS_W-1:0] sz;
    logic signed [16:0] rh_ext;
    logic signed [16:0] ang_fold;
    logic               fold;

    // Multiply both local coordinates by the unsigned gain
    assign prod_x_full = local_x * $signed({1'b0, pc2d_pkg::GAIN_Q032});
    assign prod_z_full = local_z * $signed({1'b0, pc2d_pkg::GAIN_Q032});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            rot_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            mul_vld_reg <= in_valid;
            rot_vld_reg <= mul_vld_reg;
        end
    end

    // Hold the products and the pass-through fields
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_x_reg <= prod_x_full[63:0];
            prod_z_reg <= prod_z_full[63:0];
            rh_reg     <= robot_heading;
            rx_reg     <= robot_x;
            rz_reg     <= robot_z;
            hsum_reg   <= robot_heading + local_heading;
        end
    end

    // Drop to Q.32, fold headings past a quarter turn into range
    always_comb
    begin
        sx       = pc2d_pkg::POS_W'(prod_x_reg >>> (32 - pc2d_pkg::GUARD));
        sz       = pc2d_pkg::POS_W'(prod_z_reg >>> (32 - pc2d_pkg::GUARD));
        rh_ext   = {rh_reg[15], rh_reg};
        fold     = (rh_reg > pc2d_pkg::QUARTER_TURN) || (rh_reg < -pc2d_pkg::QUARTER_TURN);
        ang_fold = rh_ext;
        rot_next = '0;
        if (fold)
        begin
            sx = -sx;
            sz = -sz;
            if (rh_reg[15])
            begin
                ang_fold = rh_ext + pc2d_pkg::HALF_TURN;
            end
            else
            begin
                ang_fold = rh_ext - pc2d_pkg::HALF_TURN;
            end
        end
        rot_next.x    = sx;
        rot_next.y    = sz;
        rot_next.ang  = {{(pc2d_pkg::ANG_W - 33){ang_fold[16]}}, ang_fold, 16'h0000};
        rot_next.rx   = rx_reg;
        rot_next.rz   = rz_reg;
        rot_next.hsum = hsum_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot_valid = rot_vld_reg;
    assign rot       = rot_reg;

endmodule

FILE: rtl/core/pc2d_cordic.sv
// ----------------------------------------------------------------------------
// pc2d_cordic
// Rotation-mode CORDIC, one register stage per micro-rotation.
// ----------------------------------------------------------------------------
module pc2d_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  pc2d_pkg::pc2d_rot_t in_rot,
    output logic                out_valid,
    output pc2d_pkg::pc2d_rot_t out_rot
);

    localparam int N = pc2d_pkg::STAGES;

    // stg_rot[0] is the input, stg_rot[g+1] the register of stage g
    pc2d_pkg::pc2d_rot_t stg_rot [0:N];
    logic                stg_vld [0:N];

    assign stg_rot[0] = in_rot;
    assign stg_vld[0] = in_valid;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic signed [pc2d_pkg::POS_W-1:0] xi;
            logic signed [pc2d_pkg::POS_W-1:0] yi;
            logic signed [pc2d_pkg::POS_W-1:0] dx;
            logic signed [pc2d_pkg::POS_W-1:0] dy;
            logic signed [pc2d_pkg::ANG_W-1:0] ai;
            logic                              vld_reg;
            pc2d_pkg::pc2d_rot_t               rot_reg;
            pc2d_pkg::pc2d_rot_t               rot_next;

            assign xi = stg_rot[g].x;
            assign yi = stg_rot[g].y;
            assign ai = stg_rot[g].ang;
            assign dx = yi >>> g;
            assign dy = xi >>> g;

            // Rotate towards zero residual angle
            always_comb
            begin
                rot_next = stg_rot[g];
                if (!ai[pc2d_pkg::ANG_W-1])
                begin
                    rot_next.x   = xi - dx;
                    rot_next.y   = yi + dy;
                    rot_next.ang = ai - pc2d_pkg::atan_angle(g);
                end
                else
                begin
                    rot_next.x   = xi + dx;
                    rot_next.y   = yi - dy;
                    rot_next.ang = ai + pc2d_pkg::atan_angle(g);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg <= 1'b0;
                end
                else if (advance)
                begin
                    vld_reg <= stg_vld[g];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rot_reg <= rot_next;
                end
            end

            assign stg_rot[g+1] = rot_reg;
            assign stg_vld[g+1] = vld_reg;
        end
    endgenerate

    assign out_valid = stg_vld[N];
    assign out_rot   = stg_rot[N];

endmodule

FILE: rtl/core/pc2d_finish.sv
// ----------------------------------------------------------------------------
// pc2d_finish
// Adds the robot position, rounds back to Q15.16 and clamps to 32 bits.
// Holds the output beat register.
// ----------------------------------------------------------------------------
module pc2d_finish (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  pc2d_pkg::pc2d_rot_t in_rot,
    output logic                out_valid,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_z,
    output logic signed [15:0]  out_heading,
    output logic                out_sat
);

    localparam int SW = pc2d_pkg::SUM_W;
    localparam int RW = pc2d_pkg::RND_W;

    logic               vld_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] z_reg;
    logic        [15:0] hdg_reg;
    logic               sat_reg;

    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_z;
    logic signed [RW-1:0] rnd_x;
    logic signed [RW-1:0] rnd_z;
    logic signed [31:0]   x_next;
    logic signed [31:0]   z_next;
    logic                 sat_x;
    logic                 sat_z;

    // Add base position with the rounding half folded into its low bits
    assign sum_x = SW'(in_rot.x)
                 + $signed({{(SW - 48){in_rot.rx[31]}}, in_rot.rx, 16'h8000});
    assign sum_z = SW'(in_rot.y)
                 + $signed({{(SW - 48){in_rot.rz[31]}}, in_rot.rz, 16'h8000});
    assign rnd_x = sum_x[SW-1:pc2d_pkg::GUARD];
    assign rnd_z = sum_z[SW-1:pc2d_pkg::GUARD];

    // Clamp to the signed 32-bit range
    always_comb
    begin
        sat_x  = (rnd_x[RW-1:31] != {(RW - 31){rnd_x[RW-1]}});
        sat_z  = (rnd_z[RW-1:31] != {(RW - 31){rnd_z[RW-1]}});
        x_next = rnd_x[31:0];
        z_next = rnd_z[31:0];
        if (sat_x)
        begin
            x_next = rnd_x[RW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        if (sat_z)
        begin
            z_next = rnd_z[RW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg   <= x_next;
            z_reg   <= z_next;
            hdg_reg <= in_rot.hsum;
            sat_reg <= sat_x || sat_z;
        end
    end

    assign out_valid   = vld_reg;
    assign out_x       = x_reg;
    assign out_z       = z_reg;
    assign out_heading = hdg_reg;
    assign out_sat     = sat_reg;

endmodule

FILE: tb/tb_pose_compose_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pose_compose_2d
// Self-checking bench for the planar pose composition core. A short table of
// corner-case beats is followed by about a thousand random beats. Both sides
// idle and stall at random. Every output beat is checked field by field
// against its table value or against a bit-exact CORDIC predictor held in the bench.
// ----------------------------------------------------------------------------
module tb_pose_compose_2d;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] rz;
        logic signed [15:0] rh;
        logic signed [31:0] lx;
        logic signed [31:0] lz;
        logic signed [15:0] lh;
    } pose_pair_t;

    typedef struct packed {
        logic signed [31:0] gx;
        logic signed [31:0] gz;
        logic signed [15:0] gh;
        logic               sat;
    } world_pose_t;

    typedef struct packed {
        pose_pair_t  stim;
        logic        typed;
        world_pose_t want;
    } steer_row_t;

    localparam int     ROT_STEPS  = (pc2d_pkg::ITERATIONS < 24) ? pc2d_pkg::ITERATIONS : 24;
    localparam int     GUARD_BITS = 16;
    localparam longint GAIN       = 64'h0000_0000_9B74_EDA8;
    localparam longint POS_MAX    = 64'sd2147483647;
    localparam longint POS_MIN    = -64'sd2147483648;
    localparam int     N_STEER    = 21;
    localparam int     N_RANDOM   = 1030;
    localparam int     DRAIN      = ROT_STEPS + 24;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_z;
    logic signed [15:0] robot_heading;
    logic signed [31:0] local_x;
    logic signed [31:0] local_z;
    logic signed [15:0] local_heading;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] global_x;
    logic signed [31:0] global_z;
    logic signed [15:0] global_heading;
    logic               saturated;

    world_pose_t pending_poses[$];
    int          mismatch_count = 0;

    // round(atan(2^-i) * 2^31 / pi)
    longint atan_steps [0:23] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    // Corner beats: zero local positions give the robot position back exactly
    steer_row_t steer_rows [0:N_STEER-1] = '{
        '{'{32'h00000000, 32'h00000000, 16'h0000, 32'h00000000, 32'h00000000, 16'h0000},
          1'b1, '{32'h00000000, 32'h00000000, 16'h0000, 1'b0}},
        '{'{32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 32'h00000000, 32'h00000000, 16'h0001},
          1'b1, '{32'h7FFFFFFF, 32'h80000000, 16'h8000, 1'b0}},
        '{'{32'h80000000, 32'h7FFFFFFF, 16'h8000, 32'h00000000, 32'h00000000, 16'hFFFF},
          1'b1, '{32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 1'b0}},
        '{'{32'h12345678, 32'hFFFFFFFB, 16'h4000, 32'h00000000, 32'h00000000, 16'h4000},
          1'b1, '{32'h12345678, 32'hFFFFFFFB, 16'h8000, 1'b0}},
        '{'{32'h7FFFFFFF, 32'h00000000, 16'h0000, 32'h7FFFFFFF, 32'h00000000, 16'h0000},
          1'b0, '0},
        '{'{32'h80000000, 32'h00000000, 16'h0000, 32'h80000000, 32'h00000000, 16'h0000},
          1'b0, '0},
        '{'{32'h00000000, 32'h7FFFFFFF, 16'h0000, 32'h00000000, 32'h7FFFFFFF, 16'h0000},
          1'b0, '0},
        '{'{32'h00000000, 32'h80000000, 16'h0000, 32'h00000000, 32'h80000000, 16'h0000},
          1'b0, '0},
        '{'{32'h00000000, 32'h00000000, 16'h4000, 32'h00010000, 32'h00000000, 16'h0000},
          1'b0, '0},
        '{'{32'h00000000, 32'h00000000, 16'h4001, 32'h00010000, 32'h00000000, 16'h0000},
          1'b0, '0},
        '{'{32'h00000000, 32'h00000000, 16'hC000, 32'h00010000, 32'h00020000, 16'h1234},
          1'b0, '0},
        '{'{32'h00000000, 32'h00000000, 16'hBFFF, 32'h00010000, 32'h00020000, 16'h0000},
          1'b0, '0},
        '{'{32'h00050000, 32'hFFFB0000, 16'h8000, 32'h00030000, 32'hFFFF0000, 16'h0000},
          1'b0, '0},
        '{'{32'h00000000, 32'h00000000, 16'h7FFF, 32'h00030000, 32'h00040000, 16'h8001},
          1'b0, '0},
        '{'{32'h00000000, 32'h00000000, 16'h2000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0000},
          1'b0, '0},
        '{'{32'h00000000, 32'h00000000, 16'hE000, 32'h80000000, 32'h80000000, 16'h0000},
          1'b0, '0},
        '{'{32'h00000000, 32'h00000000, 16'h0000, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0000},
          1'b0, '0},
        '{'{32'h00000000, 32'h00000000, 16'h0000, 32'h00000001, 32'h00000001, 16'h0000},
          1'b0, '0},
        '{'{32'h7FFF0000, 32'h00000000, 16'h0000, 32'h80000000, 32'h7FFFFFFF, 16'h5555},
          1'b0, '0},
        '{'{32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 32'h55555555, 32'hAAAAAAAA, 16'h5555},
          1'b0, '0},
        '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF},
          1'b0, '0}
    };

    pose_compose_2d dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .robot_x        (robot_x),
        .robot_z        (robot_z),
        .robot_heading  (robot_heading),
        .local_x        (local_x),
        .local_z        (local_z),
        .local_heading  (local_heading),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .global_x       (global_x),
        .global_z       (global_z),
        .global_heading (global_heading),
        .saturated      (saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Add the robot position, round off the guard bits and clamp
    function automatic logic signed [31:0] place_coord(input longint rot,
                                                       input logic signed [31:0] base,
                                                       output logic clamped);
        longint r;
        begin
            r = (rot + longint'(base) * 65536 + 32768) >>> GUARD_BITS;
            clamped = 1'b0;
            if (r > POS_MAX)
            begin
                clamped = 1'b1;
                r = POS_MAX;
            end
            else if (r < POS_MIN)
            begin
                clamped = 1'b1;
                r = POS_MIN;
            end
            return r[31:0];
        end
    endfunction

    // Rotate the local offset by the robot heading and place it in the world
    function automatic world_pose_t compose_pose(input pose_pair_t p);
        longint      x;
        longint      y;
        longint      ang;
        longint      dx;
        longint      dy;
        int          turn;
        logic        clx;
        logic        clz;
        world_pose_t w;
        begin
            x = (longint'(p.lx) * GAIN) >>> GUARD_BITS;
            y = (longint'(p.lz) * GAIN) >>> GUARD_BITS;
            turn = p.rh;
            // fold headings past a quarter turn back by half a turn
            if (turn > 16384 || turn < -16384)
            begin
                x = -x;
                y = -y;
                turn = (turn > 0) ? turn - 32768 : turn + 32768;
            end
            ang = longint'(turn) * 65536;
            for (int i = 0; i < ROT_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (ang >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    ang = ang - atan_steps[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    ang = ang + atan_steps[i];
                end
            end
            w.gx  = place_coord(x, p.rx, clx);
            w.gz  = place_coord(y, p.rz, clz);
            w.gh  = p.rh + p.lh;
            w.sat = clx | clz;
            return w;
        end
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                return 0;
            else if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(4, 25);
        end
    endfunction

    // Full range, small values, values near the limits, or the extremes, zero and minus one
    function automatic logic [31:0] rand_pos();
        int                 k;
        logic signed [31:0] v;
        begin
            k = $urandom_range(0, 9);
            v = $urandom;
            if (k < 4)
                return v;
            else if (k < 7)
                return v >>> $urandom_range(8, 22);
            else if (k < 9)
                return {v[31], {7{~v[31]}}, v[23:0]};
            case ($urandom_range(0, 3))
                0:       return 32'h7FFFFFFF;
                1:       return 32'h80000000;
                2:       return 32'h00000000;
                default: return 32'hFFFFFFFF;
            endcase
        end
    endfunction

    // Full range, or close to zero and to the quarter and half turn boundaries
    function automatic logic [15:0] rand_heading();
        int k;
        int base;
        begin
            k = $urandom_range(0, 9);
            if (k < 6)
                return 16'($urandom);
            if (k < 9)
            begin
                case ($urandom_range(0, 3))
                    0:       base = 16384;
                    1:       base = -16384;
                    2:       base = -32768;
                    default: base = 0;
                endcase
                return 16'(base + int'($urandom_range(0, 6)) - 3);
            end
            case ($urandom_range(0, 3))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h4000;
                default: return 16'hC000;
            endcase
        end
    endfunction

    // Drive one beat from a falling edge; return at the falling edge after it is taken
    task automatic send_pose(input pose_pair_t p, input int gap, input logic typed,
                             input world_pose_t want);
        begin
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            robot_x       <= p.rx;
            robot_z       <= p.rz;
            robot_heading <= p.rh;
            local_x       <= p.lx;
            local_z       <= p.lz;
            local_heading <= p.lh;
            in_valid      <= 1'b1;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            pending_poses.push_back(typed ? want : compose_pose(p));
            @(negedge clk);
        end
    endtask

    // Stall the output in bursts, with quiet stretches between
    initial
    begin : stall_gen
        int r;
        int quiet;
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            quiet = (r < 80) ? $urandom_range(1, 12) : $urandom_range(30, 120);
            repeat (quiet) @(negedge clk);
            out_stall <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 70)
                hold = $urandom_range(1, 3);
            else if (r < 95)
                hold = $urandom_range(4, 7);
            else
                hold = $urandom_range(10, 40);
            repeat (hold) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // Check each taken output beat against the oldest expectation
    always @(posedge clk)
    begin : watch_out
        world_pose_t got;
        world_pose_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{global_x, global_z, global_heading, saturated};
            if (pending_poses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected beat gx=%h gz=%h gh=%h sat=%b",
                             $realtime, got.gx, got.gz, got.gh, got.sat);
            end
            else
            begin
                want = pending_poses.pop_front();
                if (got.gx !== want.gx || got.gz !== want.gz ||
                    got.gh !== want.gh || got.sat !== want.sat)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: got gx=%h gz=%h gh=%h sat=%b, want gx=%h gz=%h gh=%h sat=%b",
                                 $realtime, got.gx, got.gz, got.gh, got.sat,
                                 want.gx, want.gz, want.gh, want.sat);
                end
            end
        end
    end

    // Hard stop if the pipeline hangs
    initial
    begin
        #(5_000_000);
        $display("** pose_compose_2d: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        pose_pair_t p;
        logic       calm;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        robot_x       = '0;
        robot_z       = '0;
        robot_heading = '0;
        local_x       = '0;
        local_z       = '0;
        local_heading = '0;
        calm          = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // walk the corner table
        for (int n = 0; n < N_STEER; n++)
            send_pose(steer_rows[n].stim, pick_gap(), steer_rows[n].typed,
                      steer_rows[n].want);

        // random beats; some blocks run with no idling at all
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            p.rx = rand_pos();
            p.rz = rand_pos();
            p.rh = rand_heading();
            p.lx = rand_pos();
            p.lz = rand_pos();
            p.lh = rand_heading();
            send_pose(p, calm ? 0 : pick_gap(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // drain, then watch for stray beats
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mismatch_count == 0 && pending_poses.size() == 0)
            $display("** pose_compose_2d: PASSED **");
        else
            $display("** pose_compose_2d: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pc2d_pkg.sv
rtl/core/pc2d_prescale.sv
rtl/core/pc2d_cordic.sv
rtl/core/pc2d_finish.sv
rtl/core/pose_compose_2d.sv
tb/tb_pose_compose_2d.sv
